>>> rtl/pf_pkg.sv
package pf_pkg;

	localparam int unsigned SIDE  = 5;
	localparam int unsigned CELLS = 25;

	// letter codes index the 25-letter alphabet without W
	localparam logic [4:0] CODE_V = 5'd21;
	localparam logic [4:0] CODE_X = 5'd22;
	localparam logic [4:0] CODE_LAST = 5'd24;

	localparam logic [7:0] ASC_SPACE = 8'h20;
	localparam logic [7:0] ASC_A     = 8'h41;
	localparam logic [7:0] ASC_W     = 8'h57;
	localparam logic [7:0] ASC_Z     = 8'h5A;
	localparam logic [7:0] ASC_LA    = 8'h61;
	localparam logic [7:0] ASC_LZ    = 8'h7A;
	localparam logic [7:0] ASC_CASE  = 8'h20;

	typedef enum logic [1:0] {
		K_KEY     = 2'd0,
		K_KEY_END = 2'd1,
		K_TEXT    = 2'd2,
		K_MSG_END = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NONLETTER = 2'd1,
		ST_W_DECRYPT = 2'd2,
		ST_NO_KEY    = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CLS_LETTER = 2'd0,
		CLS_SPACE  = 2'd1,
		CLS_W      = 2'd2,
		CLS_OTHER  = 2'd3
	} cls_t;

	typedef enum logic [1:0] {
		OUT_ERR = 2'd0,
		OUT_X   = 2'd1,
		OUT_Y   = 2'd2
	} out_sel_t;

	typedef enum logic [2:0] {
		S_IDLE   = 3'd0,
		S_DECODE = 3'd1,
		S_FILL   = 3'd2,
		S_LOOK   = 3'd3,
		S_CALC   = 3'd4,
		S_EMIT1  = 3'd5,
		S_EMIT2  = 3'd6
	} state_t;

	typedef struct packed {
		logic     capture;
		logic     key_byte;
		logic     fill_step;
		logic     key_done;
		logic     held_set;
		logic     held_clear;
		logic     pair_load;
		logic     pair_pad;
		logic     look;
		logic     calc;
		logic     push;
		out_sel_t push_sel;
		status_t  err_status;
	} dp_cmd_t;

	typedef struct packed {
		kind_t kind;
		cls_t  cls;
		logic  key_ready;
		logic  held_valid;
		logic  held_eq;
		logic  code_is_x;
		logic  out_free;
		logic  fill_last;
		logic  direction;
	} dp_stat_t;

endpackage

>>> rtl/pf_ctrl.sv
module pf_ctrl import pf_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_tvalid,
	output logic     s_tready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.capture = 1'b1;
					state_d     = S_DECODE;
				end
			end
			S_DECODE: begin
				case (stat.kind)
					K_KEY: begin
						if (stat.cls == CLS_LETTER || stat.cls == CLS_W) begin
							cmd.key_byte = 1'b1;
							state_d      = S_IDLE;
						end else if (stat.out_free) begin
							cmd.key_byte   = 1'b1;
							cmd.push       = 1'b1;
							cmd.push_sel   = OUT_ERR;
							cmd.err_status = ST_NONLETTER;
							state_d        = S_IDLE;
						end
					end
					K_KEY_END: begin
						state_d = S_FILL;
					end
					K_MSG_END: begin
						cmd.held_clear = 1'b1;
						if (stat.held_valid && stat.key_ready) begin
							cmd.pair_load = 1'b1;
							cmd.pair_pad  = 1'b1;
							state_d       = S_LOOK;
						end else begin
							state_d = S_IDLE;
						end
					end
					default: begin
						if (!stat.key_ready) begin
							if (stat.out_free) begin
								cmd.push       = 1'b1;
								cmd.push_sel   = OUT_ERR;
								cmd.err_status = ST_NO_KEY;
								state_d        = S_IDLE;
							end
						end else if (stat.cls == CLS_SPACE) begin
							state_d = S_IDLE;
						end else if (stat.cls == CLS_OTHER) begin
							if (stat.out_free) begin
								cmd.push       = 1'b1;
								cmd.push_sel   = OUT_ERR;
								cmd.err_status = ST_NONLETTER;
								state_d        = S_IDLE;
							end
						end else if (stat.cls == CLS_W && stat.direction) begin
							if (stat.out_free) begin
								cmd.push       = 1'b1;
								cmd.push_sel   = OUT_ERR;
								cmd.err_status = ST_W_DECRYPT;
								state_d        = S_IDLE;
							end
						end else if (!stat.held_valid) begin
							cmd.held_set = 1'b1;
							state_d      = S_IDLE;
						end else if (!stat.direction && stat.held_eq && !stat.code_is_x) begin
							cmd.pair_load = 1'b1;
							cmd.pair_pad  = 1'b1;
							cmd.held_set  = 1'b1;
							state_d       = S_LOOK;
						end else begin
							cmd.pair_load  = 1'b1;
							cmd.held_clear = 1'b1;
							state_d        = S_LOOK;
						end
					end
				endcase
			end
			S_FILL: begin
				cmd.fill_step = 1'b1;
				if (stat.fill_last) begin
					cmd.key_done = 1'b1;
					state_d      = S_IDLE;
				end
			end
			S_LOOK: begin
				cmd.look = 1'b1;
				state_d  = S_CALC;
			end
			S_CALC: begin
				cmd.calc = 1'b1;
				state_d  = S_EMIT1;
			end
			S_EMIT1: begin
				if (stat.out_free) begin
					cmd.push     = 1'b1;
					cmd.push_sel = OUT_X;
					state_d      = S_EMIT2;
				end
			end
			S_EMIT2: begin
				if (stat.out_free) begin
					cmd.push     = 1'b1;
					cmd.push_sel = OUT_Y;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

>>> rtl/pf_dp.sv
module pf_dp import pf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] s_tdata,
	input  logic [1:0] s_tuser,
	input  logic       cfg_we,
	input  logic       cfg_data,
	input  dp_cmd_t    cmd,
	output dp_stat_t   stat,
	input  logic       m_tready,
	output logic       m_tvalid,
	output logic [7:0] m_tdata,
	output logic       m_tlast,
	output logic [1:0] m_tuser
);

	function automatic logic [2:0] pos_row(input logic [4:0] p);
		logic [2:0] r;
		if (p < 5'd5) r = 3'd0;
		else if (p < 5'd10) r = 3'd1;
		else if (p < 5'd15) r = 3'd2;
		else if (p < 5'd20) r = 3'd3;
		else r = 3'd4;
		return r;
	endfunction

	function automatic logic [4:0] times5(input logic [2:0] r);
		return {r, 2'b00} + {2'b00, r};
	endfunction

	function automatic logic [2:0] add_mod5(input logic [2:0] v, input logic [2:0] s);
		logic [3:0] t;
		t = {1'b0, v} + {1'b0, s};
		if (t >= 4'd5) t = t - 4'd5;
		return t[2:0];
	endfunction

	function automatic logic [4:0] cell_addr(input logic [2:0] r, input logic [2:0] c);
		return times5(r) + {2'b00, c};
	endfunction

	function automatic logic [7:0] code_ascii(input logic [4:0] c);
		logic [7:0] a;
		if (c < CODE_X) a = ASC_A + {3'b000, c};
		else a = ASC_A + {3'b000, c} + 8'd1;
		return a;
	endfunction

	// input item
	kind_t      kind_q;
	logic [7:0] char_q;

	// key and pairing state
	logic       direction_q;
	logic [24:0] used_q;
	logic [4:0] fill_q;
	logic       key_ready_q;
	logic [4:0] held_q;
	logic       held_valid_q;
	logic [4:0] fill_idx_q;

	// square memories
	logic [4:0] sq_mem [CELLS];
	logic [4:0] pl_mem [CELLS];

	// pair operands and lookups
	logic [4:0] a_q, b_q;
	logic [4:0] pa_q, pb_q;
	logic [4:0] x_q, y_q;
	logic [2:0] r1, c1, r2, c2, shift;
	logic [4:0] addr1, addr2;

	// output register
	logic       out_valid_q;
	logic [7:0] out_char_q;
	logic       out_last_q;
	status_t    out_status_q;

	// classify the held byte
	logic [7:0] up;
	cls_t       cls;
	logic [4:0] code;
	logic [7:0] code_wide;

	always_comb begin
		up        = char_q;
		code_wide = 8'd0;
		if (char_q >= ASC_LA && char_q <= ASC_LZ) up = char_q - ASC_CASE;
		if (up == ASC_SPACE) begin
			cls = CLS_SPACE;
		end else if (up < ASC_A || up > ASC_Z) begin
			cls = CLS_OTHER;
		end else if (up == ASC_W) begin
			cls       = CLS_W;
			code_wide = {3'b000, CODE_V};
		end else begin
			cls       = CLS_LETTER;
			code_wide = (up < ASC_W) ? (up - ASC_A) : (up - ASC_A - 8'd1);
		end
		code = code_wide[4:0];
	end

	// letter placement, shared by key bytes and the key-end sweep
	logic        key_restart;
	logic [24:0] used_eff;
	logic [4:0]  fill_eff;
	logic [4:0]  place_code;
	logic        place_try;
	logic        place_en;

	assign key_restart = cmd.key_byte && key_ready_q;
	assign used_eff    = key_restart ? '0 : used_q;
	assign fill_eff    = key_restart ? '0 : fill_q;
	assign place_code  = cmd.fill_step ? fill_idx_q : code;
	assign place_try   = cmd.fill_step ||
		(cmd.key_byte && (cls == CLS_LETTER || cls == CLS_W));
	assign place_en    = place_try && (fill_eff <= CODE_LAST) && !used_eff[place_code];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			direction_q  <= 1'b0;
			used_q       <= '0;
			fill_q       <= '0;
			key_ready_q  <= 1'b0;
			held_q       <= '0;
			held_valid_q <= 1'b0;
			fill_idx_q   <= '0;
		end else begin
			if (cfg_we) direction_q <= cfg_data;
			if (cmd.capture) fill_idx_q <= '0;
			else if (cmd.fill_step) fill_idx_q <= fill_idx_q + 5'd1;
			if (cmd.key_byte || place_en) begin
				used_q <= used_eff | (place_en ? (25'd1 << place_code) : '0);
				fill_q <= fill_eff + {4'd0, place_en};
			end
			if (key_restart) key_ready_q <= 1'b0;
			else if (cmd.key_done) key_ready_q <= 1'b1;
			if (cmd.held_set) begin
				held_q       <= code;
				held_valid_q <= 1'b1;
			end else if (cmd.held_clear || cmd.key_done || key_restart) begin
				held_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q <= kind_t'(s_tuser);
			char_q <= s_tdata;
		end
		if (cmd.pair_load) begin
			a_q <= held_q;
			b_q <= cmd.pair_pad ? CODE_X : code;
		end
	end

	// square memory: position -> letter
	always_ff @(posedge clk) begin
		if (place_en) sq_mem[fill_eff] <= place_code;
		if (cmd.calc) begin
			x_q <= sq_mem[addr1];
			y_q <= sq_mem[addr2];
		end
	end

	// place memory: letter -> position
	always_ff @(posedge clk) begin
		if (place_en) pl_mem[place_code] <= fill_eff;
		if (cmd.look) begin
			pa_q <= pl_mem[a_q];
			pb_q <= pl_mem[b_q];
		end
	end

	// digraph rule on the looked-up positions
	always_comb begin
		r1    = pos_row(pa_q);
		r2    = pos_row(pb_q);
		c1    = 3'(pa_q - times5(r1));
		c2    = 3'(pb_q - times5(r2));
		shift = direction_q ? 3'(SIDE - 1) : 3'd1;
		if (r1 != r2 && c1 != c2) begin
			addr1 = cell_addr(r1, c2);
			addr2 = cell_addr(r2, c1);
		end else if (r1 == r2 && c1 != c2) begin
			addr1 = cell_addr(r1, add_mod5(c1, shift));
			addr2 = cell_addr(r2, add_mod5(c2, shift));
		end else begin
			addr1 = cell_addr(add_mod5(r1, shift), c1);
			addr2 = cell_addr(add_mod5(r2, shift), c2);
		end
	end

	// output register
	logic out_free;
	assign out_free = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.push) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			case (cmd.push_sel)
				OUT_X: begin
					out_char_q   <= code_ascii(x_q);
					out_last_q   <= 1'b0;
					out_status_q <= ST_OK;
				end
				OUT_Y: begin
					out_char_q   <= code_ascii(y_q);
					out_last_q   <= 1'b1;
					out_status_q <= ST_OK;
				end
				default: begin
					out_char_q   <= 8'd0;
					out_last_q   <= 1'b1;
					out_status_q <= cmd.err_status;
				end
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_char_q;
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_status_q;

	assign stat.kind       = kind_q;
	assign stat.cls        = cls;
	assign stat.key_ready  = key_ready_q;
	assign stat.held_valid = held_valid_q;
	assign stat.held_eq    = (held_q == code);
	assign stat.code_is_x  = (code == CODE_X);
	assign stat.out_free   = out_free;
	assign stat.fill_last  = (fill_idx_q == CODE_LAST);
	assign stat.direction  = direction_q;

endmodule

>>> rtl/playfair_digraph_cipher.sv
// channel   dir  handshake           payload
// s_*       in   s_tvalid/s_tready    tdata: char_in, tuser: kind
// m_*       out  m_tvalid/m_tready    tdata: char_out, tlast: last, tuser: status
// cfg_*     in   cfg_valid/cfg_ready  cfg_data: direction
//
// sequencing: an item is taken in idle and decoded in the next, then most
// items return to idle; key end walks the 25-letter alphabet in the fill
// state; a digraph goes through two registered lookups in the square memories,
// then one output transfer per letter through the single output register
// reset: arst_n clears the key, the held letter, direction and the output
// stalls: a full output register holds the controller in its decode state for
// an error result and in its emit states for a digraph; input is taken again
// only once the controller is back in idle
module playfair_digraph_cipher import pf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] char_in
	input  logic [1:0] s_tuser,   // [1:0] kind
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] char_out
	output logic       m_tlast,
	output logic [1:0] m_tuser,   // [1:0] status
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_data
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// user changes direction only while idle (not enforced); a write always lands
	assign cfg_ready = 1'b1;

	// state machine: decodes each item and sequences fill and digraph steps
	pf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// datapath: classifier, square memories, digraph rule, output register
	pf_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_data (cfg_data),
		.cmd      (cmd),
		.stat     (stat),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

`ifndef SYNTH
	// never overwrite a result that has not been taken
	a_push_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> stat.out_free)
		else $error("result pushed into a full output register");

	// one item at a time: after a transfer the input side closes
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input taken while an item is in work");

	// key end leaves a ready square and no held letter
	a_key_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.key_done |=> (stat.key_ready && !stat.held_valid))
		else $error("key end did not leave the key ready");
`endif

endmodule

>>> tb/sv/playfair_digraph_cipher_test.sv
module playfair_digraph_cipher_test;
	import pf_pkg::*;

	localparam int RANDOM_ITEMS = 1400;
	localparam int SETTLE_CYCLES = 40;   // covers the key-end walk through the alphabet
	localparam int STALL_LIMIT = 2000;   // cycles with no transfer before giving up

	typedef struct {
		logic [7:0] ch;
		logic       last;
		status_t    status;
	} cipher_result_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       s_tvalid;
	logic       s_tready;
	logic [7:0] s_tdata;    // [7:0] char_in
	logic [1:0] s_tuser;    // [1:0] kind
	logic       m_tvalid;
	logic       m_tready;
	logic [7:0] m_tdata;    // [7:0] char_out
	logic       m_tlast;
	logic [1:0] m_tuser;    // [1:0] status
	logic       cfg_valid;
	logic       cfg_ready;
	logic       cfg_data;

	// predicted cipher state
	logic [4:0]  square [CELLS];
	logic [5:0]  spot [CELLS];
	logic [24:0] used_letters = '0;
	int          fill_count = 0;
	bit          key_ok = 1'b0;
	logic [4:0]  held_code = '0;
	bit          held_ok = 1'b0;
	bit          decrypting = 1'b0;

	cipher_result_t awaited_letters[$];
	int             faults = 0;
	int             idle_cycles = 0;
	bit             calm = 1'b0;

	playfair_digraph_cipher dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// mostly no gap, some short ones, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic cls_t sort_byte(input logic [7:0] c, output logic [4:0] code);
		logic [7:0] u;
		u = c;
		code = '0;
		if (u >= ASC_LA && u <= ASC_LZ)
			u = u - ASC_CASE;
		if (u == ASC_SPACE)
			return CLS_SPACE;
		if (u < ASC_A || u > ASC_Z)
			return CLS_OTHER;
		if (u == ASC_W) begin
			code = CODE_V;
			return CLS_W;
		end
		code = (u < ASC_W) ? 5'(u - ASC_A) : 5'(u - ASC_A - 8'd1);
		return CLS_LETTER;
	endfunction

	// the alphabet skips W, so codes from X on sit one place further
	function automatic logic [7:0] letter_ascii(input logic [4:0] code);
		return (code < CODE_X) ? ASC_A + 8'(code) : ASC_A + 8'(code) + 8'd1;
	endfunction

	function automatic logic [4:0] square_at(input int r, input int c);
		return square[(r % SIDE) * SIDE + (c % SIDE)];
	endfunction

	task automatic place_code(input logic [4:0] code);
		if (fill_count >= CELLS || used_letters[code])
			return;
		square[fill_count] = code;
		spot[code] = 6'(fill_count);
		fill_count++;
		used_letters[code] = 1'b1;
	endtask

	task automatic push_result(input logic [7:0] ch, input logic last, input status_t st);
		cipher_result_t res;
		res.ch = ch;
		res.last = last;
		res.status = st;
		awaited_letters.push_back(res);
	endtask

	// rectangle, row-shift or column-shift rule on one digraph
	task automatic cipher_pair(input logic [4:0] a, input logic [4:0] b);
		int pa, pb, st, r1, c1, r2, c2;
		logic [4:0] x, y;
		pa = spot[a];
		pb = spot[b];
		st = decrypting ? SIDE - 1 : 1;
		r1 = pa / SIDE;
		c1 = pa % SIDE;
		r2 = pb / SIDE;
		c2 = pb % SIDE;
		if (r1 != r2 && c1 != c2) begin
			x = square_at(r1, c2);
			y = square_at(r2, c1);
		end else if (r1 == r2 && c1 != c2) begin
			x = square_at(r1, c1 + st);
			y = square_at(r2, c2 + st);
		end else begin
			x = square_at(r1 + st, c1);
			y = square_at(r2 + st, c2);
		end
		push_result(letter_ascii(x), 1'b0, ST_OK);
		push_result(letter_ascii(y), 1'b1, ST_OK);
	endtask

	task automatic cipher_predict(input kind_t kind, input logic [7:0] ch);
		logic [4:0] code, first;
		cls_t cls;
		case (kind)
			K_KEY: begin
				if (key_ok) begin
					used_letters = '0;
					fill_count = 0;
					key_ok = 1'b0;
					held_ok = 1'b0;
				end
				cls = sort_byte(ch, code);
				if (cls == CLS_SPACE || cls == CLS_OTHER)
					push_result(8'd0, 1'b1, ST_NONLETTER);
				else
					place_code(code);
			end
			K_KEY_END: begin
				for (int i = 0; i < CELLS; i++)
					place_code(5'(i));
				key_ok = 1'b1;
				held_ok = 1'b0;
			end
			K_MSG_END: begin
				// odd tail is padded with X
				if (held_ok && key_ok)
					cipher_pair(held_code, CODE_X);
				held_ok = 1'b0;
			end
			default: begin
				cls = sort_byte(ch, code);
				if (!key_ok)
					push_result(8'd0, 1'b1, ST_NO_KEY);
				else if (cls == CLS_OTHER)
					push_result(8'd0, 1'b1, ST_NONLETTER);
				else if (cls == CLS_W && decrypting)
					push_result(8'd0, 1'b1, ST_W_DECRYPT);
				else if (cls != CLS_SPACE) begin
					if (!held_ok) begin
						held_code = code;
						held_ok = 1'b1;
					end else if (!decrypting && held_code == code && code != CODE_X) begin
						// doubled letter: split with X and keep the new one
						first = held_code;
						held_code = code;
						cipher_pair(first, CODE_X);
					end else begin
						held_ok = 1'b0;
						cipher_pair(held_code, code);
					end
				end
			end
		endcase
	endtask

	task automatic send_item(input kind_t kind, input logic [7:0] ch);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= ch;
		do @(posedge clk); while (!s_tready);
		cipher_predict(kind, ch);
	endtask

	// hold the input until every predicted letter is out, then let the block settle
	task automatic drain_results();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (awaited_letters.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_direction(input logic d);
		drain_results();
		cfg_valid <= 1'b1;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
		decrypting = d;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [7:0] random_letter();
		return (($urandom_range(0, 1) != 0) ? ASC_A : ASC_LA) + 8'($urandom_range(0, 25));
	endfunction

	function automatic logic [7:0] key_byte();
		int r;
		r = $urandom_range(0, 99);
		if (r < 75)
			return random_letter();
		if (r < 83)
			return ($urandom_range(0, 1) != 0) ? ASC_W : ASC_W + ASC_CASE;
		if (r < 90)
			return ASC_SPACE;
		return 8'($urandom);
	endfunction

	// letters with plenty of doubles, X, W, spaces and stray bytes
	function automatic logic [7:0] text_byte(input logic [7:0] prev);
		int r;
		r = $urandom_range(0, 99);
		if (r < 12)
			return prev;
		if (r < 20)
			return ($urandom_range(0, 1) != 0) ? 8'h58 : 8'h78;
		if (r < 26)
			return ASC_SPACE;
		if (r < 31)
			return ($urandom_range(0, 1) != 0) ? ASC_W : ASC_W + ASC_CASE;
		if (r < 37)
			return 8'($urandom);
		return random_letter();
	endfunction

	task automatic test_text_before_key();
		write_direction(1'b0);
		send_item(K_TEXT, 8'h61);
		send_item(K_TEXT, 8'hFF);
		send_item(K_MSG_END, 8'h00);
	endtask

	// plain alphabet square; doubles, XX, W as V, space, stray byte, odd tail
	task automatic test_empty_key_encrypt();
		send_item(K_KEY_END, 8'hFF);
		send_item(K_TEXT, 8'h68);
		send_item(K_TEXT, 8'h49);
		send_item(K_TEXT, 8'h65);
		send_item(K_TEXT, 8'h45);
		send_item(K_TEXT, ASC_SPACE);
		send_item(K_TEXT, 8'h77);
		send_item(K_TEXT, 8'h23);
		send_item(K_TEXT, 8'h58);
		send_item(K_TEXT, 8'h78);
		send_item(K_TEXT, ASC_Z);
		send_item(K_MSG_END, 8'h00);
	endtask

	task automatic test_decrypt_rules();
		write_direction(1'b1);
		send_item(K_TEXT, ASC_W);
		send_item(K_TEXT, 8'h61);
		send_item(K_TEXT, ASC_A);
		send_item(K_TEXT, 8'h00);
		send_item(K_TEXT, 8'h51);
		send_item(K_TEXT, 8'h52);
		send_item(K_TEXT, 8'h6B);
		send_item(K_MSG_END, 8'hFF);
	endtask

	// new key over an old one, W folded into V, repeats, bad key bytes, second key end
	task automatic test_key_rebuild();
		write_direction(1'b0);
		send_item(K_KEY, 8'h51);
		send_item(K_KEY, 8'h77);
		send_item(K_KEY, 8'h56);
		send_item(K_KEY, ASC_SPACE);
		send_item(K_KEY, 8'h7B);
		send_item(K_TEXT, 8'h41);
		send_item(K_KEY_END, 8'h00);
		send_item(K_TEXT, 8'h7A);
		send_item(K_KEY_END, 8'h00);
		send_item(K_TEXT, ASC_A);
		send_item(K_TEXT, 8'h42);
		send_item(K_MSG_END, 8'h00);
	endtask

	task automatic test_random_messages();
		int count, klen, mlen, msgs;
		logic [7:0] prev, b;
		count = 0;
		while (count < RANDOM_ITEMS) begin
			calm = ($urandom_range(0, 4) == 0);
			if ($urandom_range(0, 2) == 0)
				write_direction(1'($urandom_range(0, 1)));
			if ($urandom_range(0, 3) != 0) begin
				klen = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 32) : $urandom_range(0, 8);
				repeat (klen) begin
					send_item(K_KEY, key_byte());
					count++;
				end
				// text while the new key is still open
				if ($urandom_range(0, 9) == 0) begin
					send_item(K_TEXT, 8'($urandom));
					count++;
				end
				send_item(K_KEY_END, 8'($urandom));
			end
			msgs = $urandom_range(1, 3);
			repeat (msgs) begin
				mlen = $urandom_range(1, 40);
				prev = ASC_A;
				repeat (mlen) begin
					b = text_byte(prev);
					send_item(K_TEXT, b);
					prev = b;
					count++;
					if ($urandom_range(0, 60) == 0)
						send_item(kind_t'(2'($urandom_range(0, 3))), 8'($urandom));
				end
				if ($urandom_range(0, 7) == 0)
					drain_results();
				if ($urandom_range(0, 9) != 0)
					send_item(K_MSG_END, 8'($urandom));
			end
		end
		calm = 1'b0;
	endtask

	initial begin : result_sink
		int hold;
		m_tready = 1'b0;
		hold = 0;
		forever begin
			@(negedge clk);
			if (hold != 0) begin
				m_tready <= 1'b0;
				hold--;
			end else begin
				m_tready <= 1'b1;
				hold = pick_gap();
			end
		end
	end

	always @(posedge clk) begin : check_results
		cipher_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (awaited_letters.size() == 0) begin
				$error("unexpected result: char_out %h last %b status %0d",
					m_tdata, m_tlast, m_tuser);
				faults++;
			end else begin
				want = awaited_letters.pop_front();
				if (m_tdata !== want.ch) begin
					$error("char_out: expected %h, got %h", want.ch, m_tdata);
					faults++;
				end
				if (m_tlast !== want.last) begin
					$error("last: expected %b, got %b", want.last, m_tlast);
					faults++;
				end
				if (m_tuser !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, m_tuser);
					faults++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
				|| (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = 8'd0;
		s_tuser = K_KEY;
		cfg_valid = 1'b0;
		cfg_data = 1'b0;
		for (int i = 0; i < CELLS; i++) begin
			square[i] = '0;
			spot[i] = '0;
		end
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		test_text_before_key();
		test_empty_key_encrypt();
		test_decrypt_rules();
		test_key_rebuild();
		test_random_messages();

		drain_results();
		if (faults == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

>>> playfair_digraph_cipher.f
rtl/pf_pkg.sv
rtl/pf_ctrl.sv
rtl/pf_dp.sv
rtl/playfair_digraph_cipher.sv
tb/sv/playfair_digraph_cipher_test.sv
